// ===== rtl/core/vrq_pkg.sv =====
// ---------------------------------------------------------------------------
// vrq_pkg: shared types and constants for the record ring queue
// Ring geometry, command and status codes, and the request carried from the
// front end to the back end.
// ---------------------------------------------------------------------------
package vrq_pkg;

  // Ring geometry
  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_COPY     = 64;

  localparam int PTR_W  = $clog2(RING_BYTES);
  localparam int CNT_W  = $clog2(RING_BYTES + 1);
  localparam int LEN_W  = 11;
  localparam int DATA_W = 8;
  localparam int REC_W  = 10;
  localparam int COPY_W = $clog2(MAX_COPY + 1);
  localparam int HIDX_W = $clog2(HEADER_BYTES);

  // Front-to-back request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Command codes
  localparam logic [2:0] CMD_PUSH_START = 3'd0;
  localparam logic [2:0] CMD_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] CMD_POP        = 3'd2;
  localparam logic [2:0] CMD_PEEK       = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_START,
    OP_PUSH_BYTE,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_ORDER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_WR,
    ST_HDR_RD0,
    ST_HDR_RD1,
    ST_COPY,
    ST_ZERO
  } state_t;

  // One classified request
  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } req_t;

endpackage

// ===== rtl/core/vrq_ram.sv =====
// ---------------------------------------------------------------------------
// vrq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module vrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/vrq_front.sv =====
// ---------------------------------------------------------------------------
// vrq_front: input acceptance and command classification
// Decodes each incoming item into a request and holds it in a short queue
// until the back end takes it.
// ---------------------------------------------------------------------------
module vrq_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vrq_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             q_valid,
  output vrq_pkg::req_t                    q_item,
  input  logic                             q_pop
);
  import vrq_pkg::*;

  req_t              q_mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] rd_idx;
  logic [QCNT_W-1:0] count;
  logic [2:0]        cmd;
  req_t              req;
  logic              push;

  assign cmd = s_tdata[2:0];

  // Classify the command
  always_comb begin
    req.length = s_tdata[13:3];
    req.data   = s_tdata[21:14];
    unique case (cmd)
      CMD_PUSH_START: req.op = OP_PUSH_START;
      CMD_PUSH_BYTE:  req.op = OP_PUSH_BYTE;
      CMD_POP:        req.op = OP_POP;
      CMD_PEEK:       req.op = OP_PEEK;
      CMD_CLEAR:      req.op = OP_CLEAR;
      default:        req.op = OP_BAD;
    endcase
  end

  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_idx];

  // Store accepted requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_idx] <= req;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + QIDX_W'(1);
      end
      if (q_pop) begin
        rd_idx <= rd_idx + QIDX_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/vrq_back.sv =====
// ---------------------------------------------------------------------------
// vrq_back: ring state, record storage and result generation
// Executes one request at a time against the byte ring and drives the
// registered result stage.
// ---------------------------------------------------------------------------
module vrq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  vrq_pkg::req_t                     q_item,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [vrq_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output logic [1:0]                        m_tuser
);
  import vrq_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [LEN_W-1:0]  expected, expected_next;
  logic [LEN_W-1:0]  hdr_len, hdr_len_next;
  logic [HIDX_W-1:0] hdr_idx, hdr_idx_next;
  logic [DATA_W-1:0] hdr_b0, hdr_b0_next;
  logic [LEN_W-1:0]  rec_len, rec_len_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [COPY_W-1:0] cnt, cnt_next;
  logic              is_pop, is_pop_next;

  // Result register
  logic              out_valid;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic [REC_W-1:0]  out_rec;
  logic              out_empty;
  logic [CNT_W-1:0]  out_free;

  logic              out_load;
  status_t           o_status;
  logic [DATA_W-1:0] o_data;
  logic              o_last;
  logic [REC_W-1:0]  o_rec;

  // RAM port controls
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared decisions
  logic              out_free_slot;
  logic              ring_empty;
  logic              fits;
  logic [LEN_W-1:0]  stored_now;
  logic [LEN_W-1:0]  min_len;
  logic [COPY_W-1:0] copy_n;
  logic [CNT_W:0]    freed_sum;
  logic              start_ok;
  logic              read_ok;

  vrq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Classify the pending request against the ring state
  always_comb begin
    out_free_slot = !out_valid || m_tready;
    ring_empty    = (free_count == CNT_W'(RING_BYTES));
    fits          = ({1'b0, q_item.length} + (LEN_W+1)'(HEADER_BYTES))
                    <= {1'b0, free_count};
    start_ok      = (q_item.op == OP_PUSH_START) && (expected == '0) && fits;
    read_ok       = ((q_item.op == OP_POP) || (q_item.op == OP_PEEK))
                    && (expected == '0) && !ring_empty;
    // Header length: low byte captured, high bits from the second byte
    stored_now    = {ram_rdata[LEN_W-DATA_W-1:0], hdr_b0};
    min_len       = (q_item.length < stored_now) ? q_item.length : stored_now;
    copy_n        = (min_len > LEN_W'(MAX_COPY)) ? COPY_W'(MAX_COPY)
                                                 : min_len[COPY_W-1:0];
    freed_sum     = {1'b0, free_count} + (CNT_W+1)'(stored_now)
                    + (CNT_W+1)'(HEADER_BYTES);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free_slot) begin
          if (start_ok) begin
            state_next = ST_HDR_WR;
          end else if (read_ok) begin
            state_next = ST_HDR_RD0;
          end
        end
      end
      ST_HDR_WR: begin
        if (hdr_idx == HIDX_W'(HEADER_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_HDR_RD0: state_next = ST_HDR_RD1;
      ST_HDR_RD1: state_next = (copy_n == '0) ? ST_ZERO : ST_COPY;
      ST_COPY: begin
        if (out_free_slot && cnt == COPY_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (out_free_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    free_count_next = free_count;
    expected_next   = expected;
    hdr_len_next    = hdr_len;
    hdr_idx_next    = hdr_idx;
    hdr_b0_next     = hdr_b0;
    rec_len_next    = rec_len;
    rd_ptr_next     = rd_ptr;
    cnt_next        = cnt;
    is_pop_next     = is_pop;
    q_pop           = 1'b0;
    out_load        = 1'b0;
    o_status        = STAT_OK;
    o_data          = '0;
    o_last          = 1'b1;
    o_rec           = '0;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = head;

    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free_slot) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          case (q_item.op) inside
            OP_PUSH_START: begin
              if (expected != '0) begin
                o_status = STAT_ORDER;
              end else if (!fits) begin
                o_status = STAT_FULL;
              end else begin
                free_count_next = free_count - q_item.length
                                  - CNT_W'(HEADER_BYTES);
                expected_next   = q_item.length;
                hdr_len_next    = q_item.length;
                ram_we          = 1'b1;
                ram_wdata       = q_item.length[DATA_W-1:0];
                tail_next       = tail + PTR_W'(1);
                hdr_idx_next    = HIDX_W'(1);
              end
            end
            OP_PUSH_BYTE: begin
              if (expected == '0) begin
                o_status = STAT_ORDER;
              end else begin
                ram_we        = 1'b1;
                ram_wdata     = q_item.data;
                tail_next     = tail + PTR_W'(1);
                expected_next = expected - LEN_W'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (expected != '0) begin
                o_status = STAT_ORDER;
              end else if (ring_empty) begin
                o_status = STAT_EMPTY;
              end else begin
                // Hold the request and start the header read
                q_pop       = 1'b0;
                out_load    = 1'b0;
                ram_re      = 1'b1;
                is_pop_next = (q_item.op == OP_POP);
              end
            end
            OP_CLEAR: begin
              free_count_next = CNT_W'(RING_BYTES);
              head_next       = tail;
              expected_next   = '0;
            end
            default: o_status = STAT_ORDER;
          endcase
        end
      end
      ST_HDR_WR: begin
        // Write the remaining header bytes, little endian
        ram_we       = 1'b1;
        ram_wdata    = (hdr_idx == HIDX_W'(1))
                       ? DATA_W'(hdr_len[LEN_W-1:DATA_W]) : '0;
        tail_next    = tail + PTR_W'(1);
        hdr_idx_next = hdr_idx + HIDX_W'(1);
      end
      ST_HDR_RD0: begin
        hdr_b0_next = ram_rdata;
        ram_re      = 1'b1;
        ram_raddr   = head + PTR_W'(1);
      end
      ST_HDR_RD1: begin
        rec_len_next = stored_now;
        cnt_next     = copy_n;
        ram_raddr    = head + PTR_W'(HEADER_BYTES);
        rd_ptr_next  = head + PTR_W'(HEADER_BYTES + 1);
        ram_re       = (copy_n != '0);
        if (is_pop) begin
          free_count_next = (freed_sum > (CNT_W+1)'(RING_BYTES))
                            ? CNT_W'(RING_BYTES) : freed_sum[CNT_W-1:0];
          head_next       = head + stored_now[PTR_W-1:0] + PTR_W'(HEADER_BYTES);
        end
      end
      ST_COPY: begin
        if (out_free_slot) begin
          out_load = 1'b1;
          o_data   = ram_rdata;
          o_last   = (cnt == COPY_W'(1));
          o_rec    = rec_len[REC_W-1:0];
          cnt_next = cnt - COPY_W'(1);
          // Retire the request with its final result
          q_pop    = (cnt == COPY_W'(1));
          // Fetch the next byte while this one goes out
          if (cnt != COPY_W'(1)) begin
            ram_re      = 1'b1;
            ram_raddr   = rd_ptr;
            rd_ptr_next = rd_ptr + PTR_W'(1);
          end
        end
      end
      ST_ZERO: begin
        if (out_free_slot) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          o_rec    = rec_len[REC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      free_count <= CNT_W'(RING_BYTES);
      expected   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      free_count <= free_count_next;
      expected   <= expected_next;
      out_valid  <= out_load || (out_valid && !m_tready);
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    hdr_len <= hdr_len_next;
    hdr_idx <= hdr_idx_next;
    hdr_b0  <= hdr_b0_next;
    rec_len <= rec_len_next;
    rd_ptr  <= rd_ptr_next;
    cnt     <= cnt_next;
    is_pop  <= is_pop_next;
    if (out_load) begin
      out_status <= o_status;
      out_data   <= o_data;
      out_last   <= o_last;
      out_rec    <= o_rec;
      out_empty  <= (free_count_next == CNT_W'(RING_BYTES));
      out_free   <= free_count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {(OUT_TDATA_W - CNT_W - 1 - REC_W - DATA_W)'(0),
                     out_free, out_empty, out_rec, out_data};

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(RING_BYTES))
    else $error("free count above ring size");

  a_pending_reserved: assert property (@(posedge clk) disable iff (rst)
    expected != '0 |-> free_count < CNT_W'(RING_BYTES))
    else $error("pending push without reserved space");

  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> cnt != '0)
    else $error("copy state with nothing left to copy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || m_tready))
    else $error("result register overwritten while stalled");

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ring written and read in one cycle");
`endif

endmodule

// ===== rtl/core/variable_record_ring_queue.sv =====
// ---------------------------------------------------------------------------
// variable_record_ring_queue: length-prefixed record queue on a byte ring
// Path: front-end queue, then the registered result; pop/peek read the header in between.
// Throughput: 1 push_byte, clear or rejected request per cycle unless the output stalls;
// push_start holds the back end for the header writes, pop/peek for reads and results.
// Reset: synchronous; clears pointers, counts, queue and m_tvalid, not the ring RAM.
// ---------------------------------------------------------------------------
module variable_record_ring_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] cmd, [13:3] length, [21:14] data_in, [23:22] zero
  input  logic [vrq_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] data_out, [17:8] record_length, [18] is_empty, [29:19] free_bytes
  output logic [vrq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tlast,
  // [1:0] status
  output logic [1:0]                       m_tuser
);
  import vrq_pkg::*;

  logic q_valid;
  req_t q_item;
  logic q_pop;

  vrq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  vrq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/sv/variable_record_ring_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// variable_record_ring_queue_tb: self-checking bench for the record ring queue
// Walks a short table of hand-picked requests with some results typed in,
// then random record traffic with stalls on both sides. Each request's results
// are predicted locally (or typed in) and matched beat by beat against the output stream.
// ---------------------------------------------------------------------------
module variable_record_ring_queue_tb;
  import vrq_pkg::*;

  localparam int GAP_MAX      = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int REPORT_MAX   = 10;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // One output beat, as seen on the master side
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data;
    logic                last;
    logic [REC_W-1:0]    reclen;
    logic                empty;
    logic [CNT_W-1:0]    free;
  } record_beat_t;

  // One directed request, with its single result typed in where marked
  typedef struct {
    logic [2:0]        cmd;
    int                len;
    logic [DATA_W-1:0] din;
    bit                typed;
    record_beat_t      beat;
  } ring_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [1:0] m_tuser;

  // Local copy of the ring
  logic [DATA_W-1:0] ring_mem [RING_BYTES];
  int head_ptr    = 0;
  int tail_ptr    = 0;
  int free_cnt    = RING_BYTES;
  int bytes_owed  = 0;

  record_beat_t step_beats [$];
  record_beat_t owed_beats [$];
  ring_row_t    dir_rows [$];

  int  fail_count  = 0;
  int  items_sent  = 0;
  int  idle_cycles = 0;
  bit  send_calm   = 1'b0;
  bit  recv_calm   = 1'b0;
  bit  hold_req    = 1'b0;

  variable_record_ring_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Build a beat from the current ring occupancy
  function automatic record_beat_t make_beat(status_t st, int data, bit last, int reclen);
    record_beat_t b;
    b.status = st;
    b.data   = DATA_W'(data);
    b.last   = last;
    b.reclen = REC_W'(reclen);
    b.empty  = (free_cnt == RING_BYTES);
    b.free   = CNT_W'(free_cnt);
    return b;
  endfunction

  function automatic void bump_tail();
    tail_ptr = (tail_ptr + 1) % RING_BYTES;
  endfunction

  // Apply one request to the local ring and collect its result beats
  task automatic model_ring_op(input logic [2:0] cmd, input int len,
                               input logic [DATA_W-1:0] din);
    int stored;
    int n;
    logic [DATA_W-1:0] copy_buf [MAX_COPY];
    step_beats.delete();
    case (cmd) inside
      CMD_PUSH_START: begin
        if (bytes_owed != 0) begin
          step_beats.push_back(make_beat(STAT_ORDER, 0, 1'b1, 0));
        end else if (len + HEADER_BYTES > free_cnt) begin
          step_beats.push_back(make_beat(STAT_FULL, 0, 1'b1, 0));
        end else begin
          free_cnt -= len + HEADER_BYTES;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            ring_mem[tail_ptr] = DATA_W'(len >> (8 * i));
            bump_tail();
          end
          bytes_owed = len;
          step_beats.push_back(make_beat(STAT_OK, 0, 1'b1, 0));
        end
      end
      CMD_PUSH_BYTE: begin
        if (bytes_owed == 0) begin
          step_beats.push_back(make_beat(STAT_ORDER, 0, 1'b1, 0));
        end else begin
          ring_mem[tail_ptr] = din;
          bump_tail();
          bytes_owed--;
          step_beats.push_back(make_beat(STAT_OK, 0, 1'b1, 0));
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (bytes_owed != 0) begin
          step_beats.push_back(make_beat(STAT_ORDER, 0, 1'b1, 0));
        end else if (free_cnt >= RING_BYTES) begin
          step_beats.push_back(make_beat(STAT_EMPTY, 0, 1'b1, 0));
        end else begin
          // read the little-endian header, then up to MAX_COPY data bytes
          stored = 0;
          for (int i = 0; i < HEADER_BYTES; i++)
            stored |= int'(ring_mem[(head_ptr + i) % RING_BYTES]) << (8 * i);
          n = (len < stored) ? len : stored;
          if (n > MAX_COPY) n = MAX_COPY;
          for (int i = 0; i < n; i++)
            copy_buf[i] = ring_mem[(head_ptr + HEADER_BYTES + i) % RING_BYTES];
          if (cmd == CMD_POP) begin
            free_cnt += stored + HEADER_BYTES;
            if (free_cnt > RING_BYTES) free_cnt = RING_BYTES;
            head_ptr = (head_ptr + stored + HEADER_BYTES) % RING_BYTES;
          end
          if (n == 0) begin
            step_beats.push_back(make_beat(STAT_OK, 0, 1'b1, stored));
          end else begin
            for (int i = 0; i < n; i++)
              step_beats.push_back(make_beat(STAT_OK, copy_buf[i], i == n - 1, stored));
          end
        end
      end
      CMD_CLEAR: begin
        free_cnt   = RING_BYTES;
        head_ptr   = tail_ptr;
        bytes_owed = 0;
        step_beats.push_back(make_beat(STAT_OK, 0, 1'b1, 0));
      end
      default: begin
        step_beats.push_back(make_beat(STAT_ORDER, 0, 1'b1, 0));
      end
    endcase
  endtask

  // Predict, then offer one request and hold it until accepted
  task automatic send_request(input logic [2:0] cmd, input int len,
                              input logic [DATA_W-1:0] din, input bit typed,
                              input record_beat_t typed_beat);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    model_ring_op(cmd, len, din);
    if (typed) begin
      owed_beats.push_back(typed_beat);
    end else begin
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, din, LEN_W'(len), cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if ($urandom_range(0, 99) < 4) send_calm = !send_calm;
  endtask

  task automatic send_plain(input logic [2:0] cmd, input int len, input logic [DATA_W-1:0] din);
    record_beat_t none;
    none = '0;
    send_request(cmd, len, din, 1'b0, none);
  endtask

  task automatic add_row(input logic [2:0] cmd, input int len, input logic [DATA_W-1:0] din,
                         input bit typed, input status_t st, input int reclen,
                         input bit empty, input int free);
    ring_row_t row;
    row.cmd          = cmd;
    row.len          = len;
    row.din          = din;
    row.typed        = typed;
    row.beat.status  = st;
    row.beat.data    = '0;
    row.beat.last    = 1'b1;
    row.beat.reclen  = REC_W'(reclen);
    row.beat.empty   = empty;
    row.beat.free    = CNT_W'(free);
    dir_rows.push_back(row);
  endtask

  // Supply the data bytes of an open record, now and then breaking it off;
  // drop the record once the item budget is spent
  task automatic feed_record_bytes();
    int r;
    while (bytes_owed > 0) begin
      r = $urandom_range(0, 99);
      if (r < 2 || items_sent >= dir_rows.size() + RANDOM_ITEMS) begin
        send_plain(CMD_CLEAR, $urandom_range(0, 2047), 8'($urandom));
        return;
      end
      if (r < 4) begin
        send_plain(CMD_PUSH_START, $urandom_range(0, 2047), 8'($urandom));
      end else if (r < 6) begin
        send_plain($urandom_range(0, 1) ? CMD_POP : CMD_PEEK, $urandom_range(0, 2047),
                   8'($urandom));
      end else if (r < 7) begin
        send_plain(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom_range(0, 2047),
                   8'($urandom));
      end
      send_plain(CMD_PUSH_BYTE, $urandom_range(0, 2047), 8'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    int r;
    int len;
    bit hold_armed;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    hold_armed = 1'b0;

    // directed rows: reset state, extremes, out-of-order and zero-copy cases
    add_row(CMD_POP,        5,    8'h00, 1, STAT_EMPTY, 0, 1, 1024);
    add_row(CMD_PEEK,       2047, 8'h00, 1, STAT_EMPTY, 0, 1, 1024);
    add_row(CMD_PUSH_BYTE,  0,    8'hFF, 1, STAT_ORDER, 0, 1, 1024);
    add_row(CMD_UNUSED_LO,  2047, 8'hFF, 1, STAT_ORDER, 0, 1, 1024);
    add_row(CMD_UNUSED_HI,  0,    8'h00, 1, STAT_ORDER, 0, 1, 1024);
    add_row(CMD_PUSH_START, 2047, 8'h00, 1, STAT_FULL,  0, 1, 1024);
    add_row(CMD_PUSH_START, 1021, 8'h00, 1, STAT_FULL,  0, 1, 1024);
    add_row(CMD_PUSH_START, 0,    8'h00, 1, STAT_OK,    0, 0, 1020);
    add_row(CMD_PEEK,       10,   8'h00, 1, STAT_OK,    0, 0, 1020);
    add_row(CMD_POP,        10,   8'h00, 1, STAT_OK,    0, 1, 1024);
    add_row(CMD_PUSH_START, 3,    8'h00, 1, STAT_OK,    0, 0, 1017);
    add_row(CMD_PUSH_START, 3,    8'h00, 1, STAT_ORDER, 0, 0, 1017);
    add_row(CMD_POP,        64,   8'h00, 1, STAT_ORDER, 0, 0, 1017);
    add_row(CMD_PEEK,       0,    8'h00, 1, STAT_ORDER, 0, 0, 1017);
    add_row(CMD_PUSH_BYTE,  0,    8'hFF, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_PUSH_BYTE,  0,    8'h00, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_PUSH_BYTE,  0,    8'hA5, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_PUSH_BYTE,  0,    8'h5A, 1, STAT_ORDER, 0, 0, 1017);
    add_row(CMD_PEEK,       0,    8'h00, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_PEEK,       2047, 8'h00, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_POP,        2,    8'h00, 0, STAT_OK,    0, 0, 0);
    add_row(CMD_PUSH_START, 1020, 8'h00, 1, STAT_OK,    0, 0, 0);
    add_row(CMD_PUSH_START, 0,    8'h00, 1, STAT_ORDER, 0, 0, 0);
    add_row(CMD_CLEAR,      0,    8'h00, 1, STAT_OK,    0, 1, 1024);
    add_row(CMD_CLEAR,      2047, 8'hFF, 1, STAT_OK,    0, 1, 1024);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].din, dir_rows[i].typed,
                   dir_rows[i].beat);

    // random record traffic
    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      if (!hold_armed && items_sent > dir_rows.size() + 40) begin
        hold_req   = 1'b1;
        hold_armed = 1'b1;
      end
      feed_record_bytes();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(0, 16) :
              (r < 90) ? $urandom_range(17, 80) : $urandom_range(0, 1100);
        send_plain(CMD_PUSH_START, len, 8'($urandom));
      end else if (r < 80) begin
        r = $urandom_range(0, 99);
        len = (r < 50) ? $urandom_range(0, 80) :
              (r < 85) ? $urandom_range(0, 1100) : $urandom_range(0, 2047);
        send_plain($urandom_range(0, 2) != 0 ? CMD_POP : CMD_PEEK, len, 8'($urandom));
      end else if (r < 84) begin
        send_plain(CMD_CLEAR, $urandom_range(0, 2047), 8'($urandom));
      end else begin
        send_plain(3'($urandom_range(0, 7)), $urandom_range(0, 2047), 8'($urandom));
      end
    end

    s_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("variable_record_ring_queue_tb: done, clean");
    end else begin
      $display("variable_record_ring_queue_tb: done, errors");
    end
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 99) < 4) recv_calm = !recv_calm;
    end
  end

  // Match each accepted beat against the oldest expectation
  always @(posedge clk) begin
    record_beat_t want;
    record_beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.data   = m_tdata[7:0];
      got.reclen = m_tdata[17:8];
      got.empty  = m_tdata[18];
      got.free   = m_tdata[29:19];
      got.last   = m_tlast;
      if (owed_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected beat: st=%0d d=%02h last=%0d len=%0d empty=%0d free=%0d",
                   got.status, got.data, got.last, got.reclen, got.empty, got.free);
      end else begin
        want = owed_beats.pop_front();
        if (want !== got) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: want st=%0d d=%02h last=%0d len=%0d empty=%0d free=%0d",
                     want.status, want.data, want.last, want.reclen, want.empty, want.free,
                     " | got st=%0d d=%02h last=%0d len=%0d empty=%0d free=%0d",
                     got.status, got.data, got.last, got.reclen, got.empty, got.free);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("variable_record_ring_queue_tb: done, errors");
        $finish;
      end
    end
  end

endmodule

// ===== variable_record_ring_queue.f =====
rtl/core/vrq_pkg.sv
rtl/core/vrq_ram.sv
rtl/core/vrq_front.sv
rtl/core/vrq_back.sv
rtl/core/variable_record_ring_queue.sv
tb/sv/variable_record_ring_queue_tb.sv
